// ----- rtl/bclpd_pkg.sv -----
// ----------------------------------------------------------------------------
// Button click / long-press detector package
// Shared widths, codes and register map for the detector core.
// ----------------------------------------------------------------------------
package bclpd_pkg;

    localparam int TimerWidth = 16;
    localparam int EventWidth = 2;
    localparam int AddrWidth  = 4;
    localparam int DataWidth  = 32;

    typedef logic [TimerWidth-1:0] timer_t;
    typedef logic [EventWidth-1:0] event_t;
    typedef logic [AddrWidth-1:0]  cfg_addr_t;
    typedef logic [DataWidth-1:0]  cfg_data_t;
    typedef logic [1:0]            reg_index_t;

    // event codes
    localparam event_t EV_NONE  = 2'd0;
    localparam event_t EV_CLICK = 2'd1;
    localparam event_t EV_LONG  = 2'd2;

    // item opcodes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_READ = 1'b1;

    // register indexes (byte address = 4 * index)
    localparam reg_index_t REG_DEBOUNCE   = 2'd0;
    localparam reg_index_t REG_LONG_PRESS = 2'd1;
    localparam reg_index_t REG_ACTIVE     = 2'd2;

    // reset values of the registers
    localparam timer_t DEBOUNCE_RESET   = 16'd20;
    localparam timer_t LONG_PRESS_RESET = 16'd1000;
    localparam logic   ACTIVE_RESET     = 1'b0;

    localparam timer_t TIMER_MAX = '1;

    function automatic timer_t sat_inc(input timer_t v);
        return (v == TIMER_MAX) ? v : timer_t'(v + timer_t'(1));
    endfunction

endpackage

// ----- rtl/button_click_long_press_detector_core.sv -----
// ----------------------------------------------------------------------------
// Button click / long-press detector core
// Debounces a sampled button pin and reports click and long-press events.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall, opcode, pin_level): each item is either
//   a tick (opcode 0) carrying the raw pin level, or a read (opcode 1) that
//   returns the latched event and clears it. Every item yields one result.
//   Output channel (out_valid / out_stall, event_code): 0 none, 1 click,
//   2 long press. For a tick, the latched event after the update; for a read,
//   the event before clearing.
//   Pipeline: an accepted item passes the input register, then the result
//   register, where out_valid rises. Throughput: one item per cycle while no
//   stall holds a result; the whole update is 16-bit increments, compares and
//   the state-machine step between the two registers.
//   Stall: while out_stall holds a result, the item waiting in the input
//   register stays put and in_stall rises; once the result is taken both
//   stages advance in the same cycle, so no bubble is inserted.
//   Reset (rst_n low, asynchronous): pipeline empties, state goes idle, no
//   event latched, both timers clear, registers return to debounce 20,
//   long press 1000, active level 0.
//   Configuration: APB at byte addresses 0, 4, 8; pready is always high.
//   Write registers only while no item is in flight.
// ----------------------------------------------------------------------------
module button_click_long_press_detector_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  opcode,
    input  logic                  pin_level,
    output logic                  out_valid,
    input  logic                  out_stall,
    output bclpd_pkg::event_t     event_code,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  bclpd_pkg::cfg_addr_t  paddr,
    input  bclpd_pkg::cfg_data_t  pwdata,
    output bclpd_pkg::cfg_data_t  prdata,
    output logic                  pready
);
    import bclpd_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PRESS_CONFIRM,
        ST_HELD,
        ST_RELEASE_CONFIRM
    } state_t;

    // configuration
    timer_t debounce_reg, debounce_next;
    timer_t long_press_reg, long_press_next;
    logic   active_reg, active_next;

    // detector state
    state_t state_reg, state_next;
    event_t latched_reg, latched_next;
    timer_t tick_cnt_reg, tick_cnt_next;
    timer_t hold_reg, hold_next;

    // input register
    logic   in_vld_reg, in_vld_next;
    logic   in_op_reg, in_op_next;
    logic   in_pin_reg, in_pin_next;

    // result register
    logic   out_vld_reg, out_vld_next;
    event_t event_reg, event_next;

    logic       advance;
    logic       cfg_write;
    reg_index_t cfg_index;
    timer_t     tick_inc;
    timer_t     hold_inc;
    logic       sample;
    logic       pressed;
    logic       long_reached;

    assign pready    = 1'b1;
    assign cfg_index = paddr[AddrWidth-1:2];
    assign cfg_write = psel && penable && pwrite;

    // Advance the input item when the result register is free or being taken.
    assign advance  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !advance;

    assign out_valid  = out_vld_reg;
    assign event_code = event_reg;

    always_comb
    begin
        case (cfg_index)
            REG_DEBOUNCE:   prdata = cfg_data_t'(debounce_reg);
            REG_LONG_PRESS: prdata = cfg_data_t'(long_press_reg);
            REG_ACTIVE:     prdata = cfg_data_t'(active_reg);
            default:        prdata = '0;
        endcase
    end

    // tick datapath
    assign hold_inc = (state_reg == ST_HELD || state_reg == ST_RELEASE_CONFIRM)
                      ? sat_inc(hold_reg) : hold_reg;
    assign tick_inc     = sat_inc(tick_cnt_reg);
    assign sample       = (tick_inc >= debounce_reg);
    assign pressed      = (in_pin_reg == active_reg);
    assign long_reached = (hold_inc >= long_press_reg);

    always_comb
    begin
        debounce_next   = debounce_reg;
        long_press_next = long_press_reg;
        active_next     = active_reg;
        state_next      = state_reg;
        latched_next    = latched_reg;
        tick_cnt_next   = tick_cnt_reg;
        hold_next       = hold_reg;
        in_vld_next     = in_vld_reg;
        in_op_next      = in_op_reg;
        in_pin_next     = in_pin_reg;
        out_vld_next    = out_vld_reg;
        event_next      = event_reg;

        if (cfg_write)
        begin
            case (cfg_index)
                REG_DEBOUNCE:   debounce_next   = pwdata[TimerWidth-1:0];
                REG_LONG_PRESS: long_press_next = pwdata[TimerWidth-1:0];
                REG_ACTIVE:     active_next     = pwdata[0];
                default:        ;
            endcase
        end

        // drop the result once taken; refill below if an item advances
        if (out_vld_reg && !out_stall)
            out_vld_next = 1'b0;

        if (advance)
        begin
            out_vld_next = 1'b1;
            in_vld_next  = 1'b0;
            if (in_op_reg == OP_READ)
            begin
                event_next   = latched_reg;
                latched_next = EV_NONE;
            end
            else
            begin
                hold_next     = hold_inc;
                tick_cnt_next = tick_inc;
                if (sample)
                begin
                    tick_cnt_next = '0;
                    case (state_reg)
                        ST_IDLE:
                        begin
                            if (pressed)
                                state_next = ST_PRESS_CONFIRM;
                        end
                        ST_PRESS_CONFIRM:
                        begin
                            if (pressed)
                            begin
                                state_next = ST_HELD;
                                hold_next  = '0;
                            end
                            else
                                state_next = ST_IDLE;
                        end
                        ST_HELD:
                        begin
                            if (!pressed)
                                state_next = ST_RELEASE_CONFIRM;
                            else if (long_reached)
                            begin
                                latched_next = EV_LONG;
                                state_next   = ST_RELEASE_CONFIRM;
                            end
                        end
                        default:
                        begin
                            // release confirm: no refire; bounce back to held
                            if (!pressed)
                            begin
                                if (!long_reached)
                                    latched_next = EV_CLICK;
                                state_next = ST_IDLE;
                            end
                            else if (!long_reached)
                                state_next = ST_HELD;
                        end
                    endcase
                end
                event_next = latched_next;
            end
        end

        // capture a new item into the input register
        if (in_valid && !in_stall)
        begin
            in_vld_next = 1'b1;
            in_op_next  = opcode;
            in_pin_next = pin_level;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= DEBOUNCE_RESET;
            long_press_reg <= LONG_PRESS_RESET;
            active_reg     <= ACTIVE_RESET;
            state_reg      <= ST_IDLE;
            latched_reg    <= EV_NONE;
            tick_cnt_reg   <= '0;
            hold_reg       <= '0;
            in_vld_reg     <= 1'b0;
            in_op_reg      <= OP_TICK;
            in_pin_reg     <= 1'b0;
            out_vld_reg    <= 1'b0;
            event_reg      <= EV_NONE;
        end
        else
        begin
            debounce_reg   <= debounce_next;
            long_press_reg <= long_press_next;
            active_reg     <= active_next;
            state_reg      <= state_next;
            latched_reg    <= latched_next;
            tick_cnt_reg   <= tick_cnt_next;
            hold_reg       <= hold_next;
            in_vld_reg     <= in_vld_next;
            in_op_reg      <= in_op_next;
            in_pin_reg     <= in_pin_next;
            out_vld_reg    <= out_vld_next;
            event_reg      <= event_next;
        end
    end

endmodule

// ----- dv/bclpd_event_tracker.sv -----
// ----------------------------------------------------------------------------
// Button detector event tracker
// Watches the item, result and register ports of the detector core, keeps a
// cycle-free copy of the debounce machine, compares every result with the
// event that copy predicts, and checks register reads against written values.
// ----------------------------------------------------------------------------
module bclpd_event_tracker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic                 opcode,
    input  logic                 pin_level,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  bclpd_pkg::event_t    event_code,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  bclpd_pkg::cfg_addr_t paddr,
    input  bclpd_pkg::cfg_data_t pwdata,
    input  bclpd_pkg::cfg_data_t prdata,
    input  logic                 pready,
    output int                   failures,
    output int                   pending,
    output int                   checked,
    output int                   clicks_read,
    output int                   longs_read
);
    import bclpd_pkg::*;

    typedef enum logic [1:0] {
        BTN_IDLE,
        BTN_CONFIRM_PRESS,
        BTN_HELD,
        BTN_CONFIRM_RELEASE
    } button_phase_t;

    timer_t        sample_period;
    timer_t        long_limit;
    logic          press_level;
    button_phase_t phase;
    event_t        latched;
    timer_t        since_sample;
    timer_t        held_ticks;

    event_t expected_events[$];
    int     mismatch_count;
    int     item_count;
    int     click_count;
    int     long_count;

    function automatic timer_t bump(input timer_t v);
        return (v == '1) ? v : timer_t'(v + 1'b1);
    endfunction

    // one item through the debounce machine; returns the event it reports
    task automatic advance_detector(input logic op, input logic pin, output event_t result);
        logic pressed;
        logic reached;
        if (op == OP_READ) begin
            result  = latched;
            latched = EV_NONE;
        end else begin
            if (phase == BTN_HELD || phase == BTN_CONFIRM_RELEASE)
                held_ticks = bump(held_ticks);
            since_sample = bump(since_sample);
            if (since_sample >= sample_period) begin
                since_sample = '0;
                pressed = (pin == press_level);
                reached = (held_ticks >= long_limit);
                case (phase)
                    BTN_IDLE:
                        if (pressed)
                            phase = BTN_CONFIRM_PRESS;
                    BTN_CONFIRM_PRESS:
                        if (pressed) begin
                            phase      = BTN_HELD;
                            held_ticks = '0;
                        end else begin
                            phase = BTN_IDLE;
                        end
                    BTN_HELD:
                        if (!pressed) begin
                            phase = BTN_CONFIRM_RELEASE;
                        end else if (reached) begin
                            latched = EV_LONG;
                            phase   = BTN_CONFIRM_RELEASE;
                        end
                    default:
                        if (!pressed) begin
                            if (!reached)
                                latched = EV_CLICK;
                            phase = BTN_IDLE;
                        end else if (!reached) begin
                            phase = BTN_HELD;
                        end
                endcase
            end
            result = latched;
        end
    endtask

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] %s: expected %0d, got %0d", $time, what, want, got);
    endtask

    always @(posedge clk or negedge rst_n) begin
        event_t want;
        if (!rst_n) begin
            sample_period  = DEBOUNCE_RESET;
            long_limit     = LONG_PRESS_RESET;
            press_level    = ACTIVE_RESET;
            phase          = BTN_IDLE;
            latched        = EV_NONE;
            since_sample   = '0;
            held_ticks     = '0;
            expected_events.delete();
            mismatch_count = 0;
            item_count     = 0;
            click_count    = 0;
            long_count     = 0;
        end else begin
            // compare before predicting, so a result never meets its own item
            if (out_valid && !out_stall) begin
                if (expected_events.size() == 0) begin
                    note_mismatch("result with nothing outstanding", 0, event_code);
                end else begin
                    want = expected_events.pop_front();
                    if (event_code !== want)
                        note_mismatch("event_code", want, event_code);
                end
            end
            if (in_valid && !in_stall) begin
                advance_detector(opcode, pin_level, want);
                expected_events.push_back(want);
                item_count++;
                if (opcode == OP_READ && want == EV_CLICK)
                    click_count++;
                if (opcode == OP_READ && want == EV_LONG)
                    long_count++;
            end
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (reg_index_t'(paddr >> 2))
                        REG_DEBOUNCE:   sample_period = pwdata[TimerWidth-1:0];
                        REG_LONG_PRESS: long_limit    = pwdata[TimerWidth-1:0];
                        REG_ACTIVE:     press_level   = pwdata[0];
                        default: ;
                    endcase
                end else begin
                    case (reg_index_t'(paddr >> 2))
                        REG_DEBOUNCE:
                            if (prdata !== cfg_data_t'(sample_period))
                                note_mismatch("debounce readback", sample_period, prdata);
                        REG_LONG_PRESS:
                            if (prdata !== cfg_data_t'(long_limit))
                                note_mismatch("long press readback", long_limit, prdata);
                        REG_ACTIVE:
                            if (prdata !== cfg_data_t'(press_level))
                                note_mismatch("active level readback", press_level, prdata);
                        default: ;
                    endcase
                end
            end
        end
        failures    <= mismatch_count;
        pending     <= expected_events.size();
        checked     <= item_count;
        clicks_read <= click_count;
        longs_read  <= long_count;
    end

endmodule

// ----- dv/button_click_long_press_detector_core_test.sv -----
// ----------------------------------------------------------------------------
// Button click / long-press detector core test
// Drives tick and read items through the core under a run of register
// settings, with bursty input and a wandering output stall; the event
// tracker predicts and checks every result.
// ----------------------------------------------------------------------------
module button_click_long_press_detector_core_test;
    import bclpd_pkg::*;

    // address 12 decodes to no register; writes there must be ignored
    localparam reg_index_t REG_SPARE     = 2'd3;
    localparam int TIMEOUT_CYCLES        = 2_500_000;
    // two pipeline stages, plus margin to catch stray results
    localparam int DRAIN_CYCLES          = 6;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    logic      opcode;
    logic      pin_level;
    logic      out_valid;
    logic      out_stall;
    event_t    event_code;
    logic      psel;
    logic      penable;
    logic      pwrite;
    cfg_addr_t paddr;
    cfg_data_t pwdata;
    cfg_data_t prdata;
    logic      pready;

    int failures;
    int pending;
    int checked;
    int clicks_read;
    int longs_read;

    // what the core is currently programmed with, to shape the stimulus
    timer_t cur_debounce;
    timer_t cur_long;
    logic   cur_active;

    int sent;
    int burst_left;
    bit steady;
    int settings_used;
    int stall_mode;
    int stall_span;

    button_click_long_press_detector_core uut (.*);

    bclpd_event_tracker tracker (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Receiver: pick a stall pattern, hold it for a while, then pick another.
    // Mode 0 never stalls, which gives stretches of full throughput.
    always @(negedge clk)
    begin
        if (stall_span == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_span <= $urandom_range(20, 300);
        end
        else
        begin
            stall_span <= stall_span - 1;
        end
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 4) == 0);
            2:       out_stall <= ($urandom_range(0, 2) != 0);
            default: out_stall <= ((stall_span % 7) < 3);
        endcase
    end

    // Present one item at the falling edge and hold it until the core takes it.
    task automatic push_item(input logic op, input logic pin);
        @(negedge clk);
        in_valid  <= 1'b1;
        opcode    <= op;
        pin_level <= pin;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Drop valid for a number of cycles; scramble the idle payload meanwhile.
    task automatic pause_sender(input int cycles);
        if (cycles > 0)
        begin
            @(negedge clk);
            in_valid  <= 1'b0;
            opcode    <= 1'($urandom_range(0, 1));
            pin_level <= 1'($urandom_range(0, 1));
            repeat (cycles - 1) @(negedge clk);
        end
    endtask

    // Send in bursts of random length, with a random gap before each burst
    // unless the sender is running steady.
    task automatic send(input logic op, input logic pin);
        if (burst_left == 0)
        begin
            if (!steady)
                pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
            burst_left = $urandom_range(1, 32);
        end
        burst_left--;
        push_item(op, pin);
        sent++;
    endtask

    // One tick, sometimes preceded by a read of the latched event.
    task automatic tick(input logic pin);
        if ($urandom_range(0, 9) == 0)
            send(OP_READ, 1'($urandom_range(0, 1)));
        send(OP_TICK, pin);
    endtask

    // Hold the sender until every outstanding result has come back.
    task automatic drain_results();
        pause_sender(1);
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // One APB transfer: setup cycle, then access until pready.
    task automatic cfg_access(input logic wr, input reg_index_t idx, input cfg_data_t data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= cfg_addr_t'({idx, 2'b00});
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Program all three registers with junk in the unused upper bits, poke
    // the unmapped address, then read everything back.
    task automatic apply_settings(input timer_t deb, input timer_t lng, input logic act);
        cfg_data_t junk;
        junk = $urandom;
        cfg_access(1'b1, REG_DEBOUNCE, {junk[31:16], deb});
        cfg_access(1'b1, REG_LONG_PRESS, {junk[15:0], lng});
        cfg_access(1'b1, REG_ACTIVE, {junk[31:1], act});
        cfg_access(1'b1, REG_SPARE, junk);
        cfg_access(1'b0, REG_DEBOUNCE, '0);
        cfg_access(1'b0, REG_LONG_PRESS, '0);
        cfg_access(1'b0, REG_ACTIVE, '0);
        cur_debounce = deb;
        cur_long     = lng;
        cur_active   = act;
        settings_used++;
    endtask

    // Mostly well-formed press episodes scaled to the sample interval: a
    // released lead-in, a press of random length (some bouncy), a release.
    // About one in five episodes is pure pin noise instead.
    task automatic run_episodes(input int target);
        int   stop_at;
        int   unit;
        int   span;
        int   hold_len;
        int   k;
        bit   bouncy;
        logic press_lvl;
        stop_at   = sent + target;
        unit      = (cur_debounce == 0) ? 1 : int'(cur_debounce);
        press_lvl = cur_active;
        while (sent < stop_at)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                repeat ($urandom_range(4, 24)) tick(1'($urandom_range(0, 1)));
            end
            else
            begin
                bouncy = ($urandom_range(0, 2) == 0);
                repeat ($urandom_range(0, 3 * unit)) tick(!press_lvl);
                // reach past the long threshold often, but cap very long limits
                span = 2 * int'(cur_long) + 3 * unit;
                if (span > 120)
                    span = 120;
                hold_len = $urandom_range(unit, span);
                for (k = 0; k < hold_len; k++)
                    tick((bouncy && $urandom_range(0, 5) == 0) ? !press_lvl : press_lvl);
                repeat ($urandom_range(unit, 3 * unit))
                    tick((bouncy && $urandom_range(0, 7) == 0) ? press_lvl : !press_lvl);
            end
        end
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        opcode        = OP_TICK;
        pin_level     = 1'b0;
        out_stall     = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        cur_debounce  = DEBOUNCE_RESET;
        cur_long      = LONG_PRESS_RESET;
        cur_active    = ACTIVE_RESET;
        sent          = 0;
        burst_left    = 0;
        steady        = 1'b0;
        settings_used = 1;
        stall_mode    = 0;
        stall_span    = 0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset values: read the registers, then hold the pin at the default
        // active level long enough for two samples at the default divider.
        cfg_access(1'b0, REG_DEBOUNCE, '0);
        cfg_access(1'b0, REG_LONG_PRESS, '0);
        cfg_access(1'b0, REG_ACTIVE, '0);
        repeat (45) send(OP_TICK, 1'b0);
        send(OP_READ, 1'b1);

        // Directed: sample every tick, long press at 3 hold ticks.
        drain_results();
        apply_settings(16'd0, 16'd3, 1'b1);
        // release to idle, clear whatever is latched
        send(OP_TICK, 1'b0);
        send(OP_TICK, 1'b0);
        send(OP_READ, 1'b0);
        // short press: click
        send(OP_TICK, 1'b1);
        send(OP_TICK, 1'b1);
        send(OP_TICK, 1'b0);
        send(OP_TICK, 1'b0);
        // long press over the unread click, keep holding (no second fire),
        // then release without a click
        repeat (6) send(OP_TICK, 1'b1);
        send(OP_TICK, 1'b0);
        send(OP_READ, 1'b1);
        send(OP_READ, 1'b0);
        // bounce back to held, then cross the threshold while confirming
        // release: neither event
        send(OP_TICK, 1'b1);
        send(OP_TICK, 1'b1);
        send(OP_TICK, 1'b0);
        send(OP_TICK, 1'b1);
        send(OP_TICK, 1'b0);
        send(OP_TICK, 1'b1);
        send(OP_TICK, 1'b0);
        send(OP_READ, 1'b1);

        // Random phases across the register extremes.
        drain_results();
        apply_settings(16'd1, 16'd4, 1'b1);
        run_episodes(150);

        // long press period zero: fires on the first held sample
        drain_results();
        apply_settings(16'd0, 16'd0, 1'b0);
        run_episodes(100);

        drain_results();
        apply_settings(16'd3, 16'd20, 1'b0);
        run_episodes(200);

        // long press never reachable in this phase: clicks only
        drain_results();
        apply_settings(16'd2, 16'hffff, 1'b1);
        run_episodes(120);

        // slowest divider: no sample falls inside this short phase
        drain_results();
        apply_settings(16'hffff, 16'd1, 1'b0);
        repeat (30) tick(1'($urandom_range(0, 1)));

        // steady sender, then a full pause mid-phase, then bursty again
        drain_results();
        apply_settings(16'd1, 16'd1, 1'b0);
        steady = 1'b1;
        run_episodes(75);
        drain_results();
        steady = 1'b0;
        run_episodes(75);

        drain_results();
        $display("Ran %0d items under %0d register settings with bursty input and stalls.",
                 checked, settings_used);
        $display("Read back %0d click and %0d long-press events.", clicks_read, longs_read);
        if (failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog: end a hung run.
    initial
    begin
        #(8 * TIMEOUT_CYCLES);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
